@@ sv/frcm_pkg.sv @@
// Shared types, constants and helper functions of the framed command receiver.
// Used by frcm_parser, frcm_mix and framed_command_receiver_mecanum_unit.
package frcm_pkg;

  // Frame sync bytes.
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  // Payload bytes kept for decoding and expected payload lengths.
  localparam int         HEAD_BYTES  = 6;
  localparam logic [7:0] CTRL_LEN    = 8'd6;
  localparam logic [7:0] HBEAT_LEN   = 8'd1;

  // Watchdog timing.
  localparam logic [15:0] TICK_MS      = 16'd10;
  localparam logic [15:0] WD_SAT_START = 16'd65525;
  localparam logic [15:0] WD_MAX       = 16'hFFFF;

  // Configuration reset values.
  localparam logic [15:0] FAILSAFE_LIMIT_RST = 16'd500;
  localparam logic [7:0]  CTRL_CMD_RST       = 8'd1;
  localparam logic [7:0]  HBEAT_CMD_RST      = 8'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FAILSAFE_LIMIT = 2'd0,
    CFG_CONTROL_CMD    = 2'd1,
    CFG_HEARTBEAT_CMD  = 2'd2
  } cfg_index_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_CMD     = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] wheel_front_left;
    logic signed [15:0] wheel_front_right;
    logic signed [15:0] wheel_rear_left;
    logic signed [15:0] wheel_rear_right;
    logic        [7:0]  peer_status;
    logic               link_up;
    logic               failsafe_on;
    logic        [15:0] good_frames;
    logic        [15:0] bad_frames;
  } out_item_t;

  // What the parser reports for the byte it is taking right now.
  typedef struct packed {
    logic                          good;
    logic                          error;
    logic [7:0]                    command;
    logic [7:0]                    length;
    logic [HEAD_BYTES-1:0][7:0]    head;
  } evt_t;

  typedef struct packed {
    logic signed [15:0] front_left;
    logic signed [15:0] front_right;
    logic signed [15:0] rear_left;
    logic signed [15:0] rear_right;
  } wheels_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ sv/frcm_parser.sv @@
// Byte-level frame parser: sync detection, running sum checksum, payload capture.
// Depends on frcm_pkg.
module frcm_parser #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output frcm_pkg::evt_t    evt
);

  localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME_BYTES - 5);

  frcm_pkg::phase_t phase, phase_next;
  logic [7:0] command, command_next;
  logic [7:0] length, length_next;
  logic [7:0] count, count_next;
  logic [7:0] sum, sum_next;
  logic [frcm_pkg::HEAD_BYTES-1:0][7:0] head;
  logic       head_we;
  logic [7:0] sum_add;
  logic       good_hit;
  logic       error_hit;

  assign sum_add = sum + rx_byte;

  always_comb begin
    phase_next   = phase;
    command_next = command;
    length_next  = length;
    count_next   = count;
    sum_next     = sum;
    head_we      = 1'b0;
    good_hit     = 1'b0;
    error_hit    = 1'b0;
    case (phase)
      frcm_pkg::PH_IDLE: begin
        if (rx_byte == frcm_pkg::SYNC_FIRST) begin
          sum_next   = frcm_pkg::SYNC_FIRST;
          phase_next = frcm_pkg::PH_HEADER;
        end
      end
      frcm_pkg::PH_HEADER: begin
        if (rx_byte == frcm_pkg::SYNC_SECOND) begin
          sum_next   = sum_add;
          phase_next = frcm_pkg::PH_CMD;
        end else if (rx_byte == frcm_pkg::SYNC_FIRST) begin
          // A repeated first sync byte restarts the header.
          sum_next = frcm_pkg::SYNC_FIRST;
        end else begin
          phase_next  = frcm_pkg::PH_IDLE;
          count_next  = '0;
          length_next = '0;
        end
      end
      frcm_pkg::PH_CMD: begin
        command_next = rx_byte;
        sum_next     = sum_add;
        phase_next   = frcm_pkg::PH_LEN;
      end
      frcm_pkg::PH_LEN: begin
        length_next = rx_byte;
        count_next  = '0;
        sum_next    = sum_add;
        if (rx_byte == 8'd0) begin
          phase_next = frcm_pkg::PH_CHECK;
        end else if (rx_byte > LEN_LIMIT) begin
          error_hit   = 1'b1;
          phase_next  = frcm_pkg::PH_IDLE;
          length_next = '0;
        end else begin
          phase_next = frcm_pkg::PH_PAYLOAD;
        end
      end
      frcm_pkg::PH_PAYLOAD: begin
        head_we    = (count < 8'(frcm_pkg::HEAD_BYTES));
        count_next = count + 8'd1;
        sum_next   = sum_add;
        if (count_next >= length) begin
          phase_next = frcm_pkg::PH_CHECK;
        end
      end
      frcm_pkg::PH_CHECK: begin
        if (rx_byte == sum) begin
          good_hit = 1'b1;
        end else begin
          error_hit = 1'b1;
        end
        phase_next  = frcm_pkg::PH_IDLE;
        count_next  = '0;
        length_next = '0;
      end
      default: begin
        phase_next  = frcm_pkg::PH_IDLE;
        count_next  = '0;
        length_next = '0;
      end
    endcase
  end

  // The frame fields are read while still in the check phase, before they clear.
  assign evt = {good_hit, error_hit, command, length, head};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= frcm_pkg::PH_IDLE;
      command <= '0;
      length  <= '0;
      count   <= '0;
      sum     <= '0;
    end else if (take) begin
      phase   <= phase_next;
      command <= command_next;
      length  <= length_next;
      count   <= count_next;
      sum     <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && head_we) begin
      head[count[2:0]] <= rx_byte;
    end
  end

endmodule

@@ sv/frcm_mix.sv @@
// Mecanum wheel mixing with 16-bit saturation.
// Depends on frcm_pkg.
module frcm_mix (
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] rot_z,
  output frcm_pkg::wheels_t  wheels
);

  logic signed [17:0] x, y, z;

  assign x = $signed({{2{vel_x[15]}}, vel_x});
  assign y = $signed({{2{vel_y[15]}}, vel_y});
  assign z = $signed({{2{rot_z[15]}}, rot_z});

  assign wheels.front_left  = frcm_pkg::sat16(x - y - z);
  assign wheels.front_right = frcm_pkg::sat16(x + y + z);
  assign wheels.rear_left   = frcm_pkg::sat16(x + y - z);
  assign wheels.rear_right  = frcm_pkg::sat16(x - y + z);

endmodule

@@ sv/framed_command_receiver_mecanum_unit.sv @@
// Top level of the framed command receiver for a mecanum-wheel base.
// Depends on frcm_pkg, frcm_parser and frcm_mix.
//
//   Port group      Direction  Handshake            Contents
//   in_*            input      in_valid / in_ready  operation (byte or tick), rx_byte
//   out_*           output     out_valid/out_ready  velocities, wheels, status, flags, counters
//   cfg_*           input      cfg_we only          failsafe limit, control and heartbeat command
//
// One transaction is taken per clock cycle at full rate while out_ready is high. An
// accepted item is held in the input register, then the parser and the state update run in
// one step, whose result is registered in the state; that single update step sets the rate.
// The result register is the state itself: the status outputs show the state after the
// latest processed item. While a result waits for out_ready, one more transaction is
// still taken into the input register; only then does in_ready drop.
// Reset is synchronous; no memory needs a clearing pass.
module framed_command_receiver_mecanum_unit #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frcm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frcm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers.
  logic [15:0] failsafe_limit;
  logic [7:0]  control_cmd;
  logic [7:0]  heartbeat_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_limit <= frcm_pkg::FAILSAFE_LIMIT_RST;
      control_cmd    <= frcm_pkg::CTRL_CMD_RST;
      heartbeat_cmd  <= frcm_pkg::HBEAT_CMD_RST;
    end else if (cfg_we) begin
      case (frcm_pkg::cfg_index_t'(cfg_index))
        frcm_pkg::CFG_FAILSAFE_LIMIT: failsafe_limit <= cfg_data;
        frcm_pkg::CFG_CONTROL_CMD:    control_cmd    <= cfg_data[7:0];
        frcm_pkg::CFG_HEARTBEAT_CMD:  heartbeat_cmd  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register. It advances whenever the result slot is free or being emptied.
  logic               s1_valid;
  frcm_pkg::in_item_t s1_item;
  logic               s1_go;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Parser only sees received bytes, never ticks.
  logic           is_tick;
  logic           take_byte;
  frcm_pkg::evt_t evt;

  assign is_tick   = s1_item.operation;
  assign take_byte = s1_go && !is_tick;

  frcm_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take_byte),
    .rx_byte (s1_item.rx_byte),
    .evt     (evt)
  );

  // Velocity decode from the captured payload, little-endian 16-bit words.
  logic signed [15:0] new_vx, new_vy, new_wz;
  frcm_pkg::wheels_t  new_wheels;

  assign new_vx = $signed({evt.head[1], evt.head[0]});
  assign new_vy = $signed({evt.head[3], evt.head[2]});
  assign new_wz = $signed({evt.head[5], evt.head[4]});

  frcm_mix u_mix (
    .vel_x  (new_vx),
    .vel_y  (new_vy),
    .rot_z  (new_wz),
    .wheels (new_wheels)
  );

  // Architectural state; it also serves as the result register.
  logic signed [15:0] vel_x, vel_x_next;
  logic signed [15:0] vel_y, vel_y_next;
  logic signed [15:0] rot_z, rot_z_next;
  frcm_pkg::wheels_t  wheels, wheels_next;
  logic [7:0]         status, status_next;
  logic               link, link_next;
  logic               failsafe, failsafe_next;
  logic [15:0]        watchdog, watchdog_next;
  logic [15:0]        good_cnt, good_cnt_next;
  logic [15:0]        bad_cnt, bad_cnt_next;

  logic [15:0] wd_inc;
  logic        is_ctrl, is_hbeat;
  logic        len_wrong;

  assign wd_inc   = (watchdog > frcm_pkg::WD_SAT_START) ? frcm_pkg::WD_MAX
                                                       : watchdog + frcm_pkg::TICK_MS;
  // When both command registers match, the frame is treated as a control frame.
  assign is_ctrl  = (evt.command == control_cmd);
  assign is_hbeat = !is_ctrl && (evt.command == heartbeat_cmd);
  assign len_wrong = (is_ctrl && evt.length != frcm_pkg::CTRL_LEN) ||
                     (is_hbeat && evt.length != frcm_pkg::HBEAT_LEN);

  always_comb begin
    vel_x_next    = vel_x;
    vel_y_next    = vel_y;
    rot_z_next    = rot_z;
    wheels_next   = wheels;
    status_next   = status;
    link_next     = link;
    failsafe_next = failsafe;
    watchdog_next = watchdog;
    good_cnt_next = good_cnt;
    bad_cnt_next  = bad_cnt;
    if (is_tick) begin
      watchdog_next = wd_inc;
      // The timeout is judged on the incremented watchdog value.
      if (wd_inc >= failsafe_limit && !failsafe) begin
        failsafe_next = 1'b1;
        link_next     = 1'b0;
        vel_x_next    = '0;
        vel_y_next    = '0;
        rot_z_next    = '0;
        wheels_next   = '0;
      end
    end else begin
      if (evt.good) begin
        watchdog_next = '0;
        failsafe_next = 1'b0;
        link_next     = 1'b1;
        good_cnt_next = good_cnt + 16'd1;
        if (is_ctrl && !len_wrong) begin
          vel_x_next  = new_vx;
          vel_y_next  = new_vy;
          rot_z_next  = new_wz;
          wheels_next = new_wheels;
        end
        if (is_hbeat && !len_wrong) begin
          status_next = evt.head[0];
        end
      end
      // A good frame with a bad length for its command is also an error.
      if (evt.error || (evt.good && len_wrong)) begin
        bad_cnt_next = bad_cnt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_x    <= '0;
      vel_y    <= '0;
      rot_z    <= '0;
      wheels   <= '0;
      status   <= '0;
      link     <= 1'b0;
      failsafe <= 1'b1;
      watchdog <= '0;
      good_cnt <= '0;
      bad_cnt  <= '0;
    end else if (s1_go) begin
      vel_x    <= vel_x_next;
      vel_y    <= vel_y_next;
      rot_z    <= rot_z_next;
      wheels   <= wheels_next;
      status   <= status_next;
      link     <= link_next;
      failsafe <= failsafe_next;
      watchdog <= watchdog_next;
      good_cnt <= good_cnt_next;
      bad_cnt  <= bad_cnt_next;
    end
  end

  assign out_data.vel_x             = vel_x;
  assign out_data.vel_y             = vel_y;
  assign out_data.rot_z             = rot_z;
  assign out_data.wheel_front_left  = wheels.front_left;
  assign out_data.wheel_front_right = wheels.front_right;
  assign out_data.wheel_rear_left   = wheels.rear_left;
  assign out_data.wheel_rear_right  = wheels.rear_right;
  assign out_data.peer_status       = status;
  assign out_data.link_up           = link;
  assign out_data.failsafe_on       = failsafe;
  assign out_data.good_frames       = good_cnt;
  assign out_data.bad_frames        = bad_cnt;

endmodule
